### sv/assert_macros.svh
// Assertion macros for the UUID extractor, included by its top-level RTL file.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/smbuuid_pkg.sv
// Shared types and constants for the SMBIOS system UUID extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smbuuid_pkg;

    localparam logic [7:0] C_TYPE_SYSTEM = 8'h01;
    localparam logic [7:0] C_MIN_LENGTH  = 8'h19;
    localparam logic [7:0] C_HEADER_LEN  = 8'h04;
    localparam logic [7:0] C_UUID_FIRST  = 8'h08;
    localparam logic [7:0] C_UUID_SPLIT  = 8'h10;
    localparam logic [7:0] C_UUID_END    = 8'h18;
    localparam logic [7:0] C_BYTE_ZERO   = 8'h00;
    localparam logic [7:0] C_BYTE_ONES   = 8'hFF;

    localparam logic C_STATUS_FOUND     = 1'b0;
    localparam logic C_STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
    } t_result;

endpackage

### sv/smbuuid_system_uuid_extract.sv
// SMBIOS system UUID extractor: takes the structure table one byte per item,
// starting at the first structure header, and gives one result per table: the
// UUID of the first type-1 structure of length 0x19 or more (first three fields
// byte-reversed), or not-found for a short header length, an all-0x00 or
// all-0xFF UUID, or a table that ends first. One byte item can be taken every
// cycle except as below; the walker forms a result combinationally from the
// byte in the input register, and it loads into the result register as that
// byte leaves the input register. While a result waits in a stalled result
// register, only a byte that would give another result holds in the input
// register; other bytes keep flowing.
// Bytes after a result are dropped until the table's last byte, after which
// the block is ready for the next table.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smbios_system_uuid_extract import smbuuid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [63:0] o_uuid_high,
    output logic [63:0] o_uuid_low
);

    t_item   w_in_item;
    t_item   w_item;
    t_result w_walk_result;
    t_result w_out_result;
    logic    w_item_valid;
    logic    w_out_free;
    logic    w_take;
    logic    w_fire;
    logic    w_emit;
    logic    w_done;

    assign w_in_item.data_byte = i_data_byte;
    assign w_in_item.last_byte = i_last_byte;

    // Hold an item that gives a result until the result register can take it.
    assign w_take = !w_emit || w_out_free;
    assign w_fire = w_item_valid && w_take;

    smbuuid_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    smbuuid_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_emit   (w_emit),
        .o_result (w_walk_result),
        .o_done   (w_done)
    );

    smbuuid_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_emit),
        .i_result (w_walk_result),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out_result)
    );

    assign o_status    = w_out_result.status;
    assign o_uuid_high = w_out_result.uuid_high;
    assign o_uuid_low  = w_out_result.uuid_low;

    `ASSERT_IMPLY(a_notfound_zero, i_clk, i_rst_n, o_valid && o_status == C_STATUS_NOT_FOUND, o_uuid_high == 64'd0 && o_uuid_low == 64'd0, "not-found result carries a nonzero uuid")
    `ASSERT_IMPLY(a_one_per_table, i_clk, i_rst_n, w_fire && w_done && !w_item.last_byte, !w_emit, "second result within one table")
    `ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n, w_fire && w_emit && !w_item.last_byte, w_done, "walker not done after a result")
    `ASSERT_ALWAYS(a_stall_needs_item, i_clk, i_rst_n, !o_stall || w_item_valid, "input stalled with an empty input register")

endmodule

### sv/smbuuid_in_reg.sv
// Input register stage for the UUID extractor: holds one table byte item.
// Depends on smbuuid_pkg for the item type.
`timescale 1ns / 1ps

module smbuuid_in_reg import smbuuid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/smbuuid_walker.sv
// Structure walker: tracks header, formatted area and string area of each
// SMBIOS structure and forms the result. Depends on smbuuid_pkg.
`timescale 1ns / 1ps

module smbuuid_walker import smbuuid_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_emit,
    output t_result o_result,
    output logic    o_done
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FORMATTED,
        PH_STRINGS,
        PH_DONE
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_offset,    n_offset;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_length,    n_length;
    logic [63:0] r_cap_hi,    n_cap_hi;
    logic [63:0] r_cap_lo,    n_cap_lo;
    logic        r_all_zero,  n_all_zero;
    logic        r_all_ones,  n_all_ones;
    logic        r_prior_zero, n_prior_zero;

    logic [7:0]  w_offset_inc;
    logic        w_emit;
    logic        w_found;
    logic [7:0]  b;

    // Undo the little-endian order of the first three UUID fields.
    function automatic logic [63:0] reorder_uuid(input logic [63:0] raw);
        reorder_uuid = {raw[39:32], raw[47:40], raw[55:48], raw[63:56],
                        raw[23:16], raw[31:24], raw[7:0],   raw[15:8]};
    endfunction

    assign b            = i_item.data_byte;
    assign w_offset_inc = r_offset + 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_offset     = r_offset;
        n_type       = r_type;
        n_length     = r_length;
        n_cap_hi     = r_cap_hi;
        n_cap_lo     = r_cap_lo;
        n_all_zero   = r_all_zero;
        n_all_ones   = r_all_ones;
        n_prior_zero = r_prior_zero;
        w_emit       = 1'b0;
        w_found      = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_offset == 8'd0) begin
                    n_type     = b;
                    n_cap_hi   = '0;
                    n_cap_lo   = '0;
                    n_all_zero = 1'b1;
                    n_all_ones = 1'b1;
                end else if (r_offset == 8'd1) begin
                    n_length = b;
                end
                n_offset = w_offset_inc;
                if (w_offset_inc == C_HEADER_LEN) begin
                    if (r_length < C_HEADER_LEN) begin
                        w_emit = 1'b1;
                    end else if (r_length == C_HEADER_LEN) begin
                        n_phase      = PH_STRINGS;
                        n_prior_zero = 1'b0;
                    end else begin
                        n_phase = PH_FORMATTED;
                    end
                end
            end
            PH_FORMATTED: begin
                if (r_offset >= C_UUID_FIRST && r_offset < C_UUID_END) begin
                    if (r_offset < C_UUID_SPLIT) begin
                        n_cap_hi = {r_cap_hi[55:0], b};
                    end else begin
                        n_cap_lo = {r_cap_lo[55:0], b};
                    end
                    if (b != C_BYTE_ZERO) n_all_zero = 1'b0;
                    if (b != C_BYTE_ONES) n_all_ones = 1'b0;
                end
                n_offset = w_offset_inc;
                if (w_offset_inc == r_length) begin
                    if (r_type == C_TYPE_SYSTEM && r_length >= C_MIN_LENGTH) begin
                        w_emit  = 1'b1;
                        w_found = !(n_all_zero || n_all_ones);
                    end else begin
                        n_phase      = PH_STRINGS;
                        n_prior_zero = 1'b0;
                    end
                end
            end
            PH_STRINGS: begin
                if (b == C_BYTE_ZERO && r_prior_zero) begin
                    n_phase      = PH_HEADER;
                    n_offset     = 8'd0;
                    n_prior_zero = 1'b0;
                end else begin
                    n_prior_zero = (b == C_BYTE_ZERO);
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // A table end with no result yet still gives one (not found).
        if (!w_emit && i_item.last_byte && n_phase != PH_DONE) begin
            w_emit = 1'b1;
        end

        if (w_emit && !i_item.last_byte) begin
            n_phase = PH_DONE;
        end

        // Table end: return everything to the reset state for the next table.
        if (i_item.last_byte) begin
            n_phase      = PH_HEADER;
            n_offset     = 8'd0;
            n_type       = 8'd0;
            n_length     = 8'd0;
            n_cap_hi     = '0;
            n_cap_lo     = '0;
            n_all_zero   = 1'b1;
            n_all_ones   = 1'b1;
            n_prior_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_offset     <= 8'd0;
            r_type       <= 8'd0;
            r_length     <= 8'd0;
            r_cap_hi     <= '0;
            r_cap_lo     <= '0;
            r_all_zero   <= 1'b1;
            r_all_ones   <= 1'b1;
            r_prior_zero <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_offset     <= n_offset;
            r_type       <= n_type;
            r_length     <= n_length;
            r_cap_hi     <= n_cap_hi;
            r_cap_lo     <= n_cap_lo;
            r_all_zero   <= n_all_zero;
            r_all_ones   <= n_all_ones;
            r_prior_zero <= n_prior_zero;
        end
    end

    // The capture is complete and unchanged on the byte that finds the UUID.
    always_comb begin
        if (w_found) begin
            o_result.status    = C_STATUS_FOUND;
            o_result.uuid_high = reorder_uuid(r_cap_hi);
            o_result.uuid_low  = r_cap_lo;
        end else begin
            o_result.status    = C_STATUS_NOT_FOUND;
            o_result.uuid_high = '0;
            o_result.uuid_low  = '0;
        end
    end

    assign o_emit = w_emit;
    assign o_done = (r_phase == PH_DONE);

endmodule

### sv/smbuuid_out_reg.sv
// Result register for the UUID extractor: holds one result item until taken.
// Depends on smbuuid_pkg for the result type.
`timescale 1ns / 1ps

module smbuuid_out_reg import smbuuid_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
